// ===== sv/cse_pkg.sv =====
// shared types and constants of the chebyshev series evaluator
package cse_pkg;

  localparam int COEF_W   = 32;  // q16.16 word
  localparam int IDX_W    = 4;   // coef_index field
  localparam int CNT_W    = 5;   // coefficient_count register
  localparam int NUM_W    = 35;  // 2x - a - b, exact
  localparam int MAG_W    = 34;  // magnitude of the numerator
  localparam int QUO_W    = 31;  // quotient bits of the mapped coordinate
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 37;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic signed [COEF_W-1:0] LOWER_RST = 32'sd0;
  localparam logic signed [COEF_W-1:0] UPPER_RST = 32'sd65536;
  localparam logic [CNT_W-1:0]         COUNT_RST = 5'd1;

  localparam logic signed [COEF_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [COEF_W-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] t;
  } div_rsp_t;

  typedef struct packed {
    logic                    start;
    logic                    inverted;
    logic                    last;
    logic signed [NUM_W-1:0] num;
    logic [COEF_W-1:0]       den;
  } eval_req_t;

  typedef struct packed {
    logic                     valid;
    logic signed [COEF_W-1:0] y;
    logic                     status;
    logic                     batch_end;
  } eval_res_t;

endpackage

// ===== sv/cse_if.sv =====
// request and result channel interfaces
interface cse_in_if import cse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [COEF_W-1:0] x_value;
  logic                     last_point;

  modport source (output valid, operation, coef_index, coef_value, x_value, last_point,
                  input ready);
  modport sink (input valid, operation, coef_index, coef_value, x_value, last_point,
                output ready);
endinterface

interface cse_out_if import cse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] y_value;
  logic                     status;
  logic                     batch_end;

  modport source (output valid, y_value, status, batch_end, input ready);
  modport sink (input valid, y_value, status, batch_end, output ready);
endinterface

// ===== sv/chebyshev_series_evaluator.sv =====
// top level of the chebyshev series evaluator
//
// Evaluates a Chebyshev series of up to MAX_COEFFICIENTS Q16.16 terms with
// the Clenshaw recurrence (constant term added in full). A load request
// (operation 1) writes one coefficient into the store; slots at or beyond
// MAX_COEFFICIENTS are dropped. An evaluate request maps x from
// [lower_bound, upper_bound] to a Q2.30 coordinate, runs the recurrence and
// returns one saturated Q16.16 value. An evaluate request occupies the block
// from its accept cycle through the one-bit-per-cycle coordinate divider
// (which stops without iterating when the coordinate saturates), a multiply
// and an accumulate step per term, because each term goes through the
// multiplier register and the accumulate against the store's registered read
// port, and a result state that holds until the output register can take
// the result. With an inverted or empty interval the engine skips divider
// and recurrence and returns status 1, value 0. The result sits in an output
// register, so the next request is taken while a finished result waits
// downstream. Coefficients must be loaded before they are used; the store has no reset.
module chebyshev_series_evaluator import cse_pkg::*; #(
  parameter int MAX_COEFFICIENTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  cse_in_if.sink               in_chan,
  cse_out_if.source            out_chan
);

  localparam int ADDR_W = (MAX_COEFFICIENTS > 1) ? $clog2(MAX_COEFFICIENTS) : 1;
  // wide enough for the count register, the slot field and the depth
  localparam int CMP_W  = $clog2(MAX_COEFFICIENTS + 1) + CNT_W;

  // configuration registers
  logic signed [COEF_W-1:0] lower_r, upper_r;
  logic [CNT_W-1:0]         count_r;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [COEF_W-1:0] out_y_r;
  logic                     out_status_r;
  logic                     out_bend_r;

  logic                     engine_idle;
  logic                     in_fire;
  logic                     load_fire;
  logic                     slot_ok;
  logic [ADDR_W-1:0]        k_start;
  logic [CMP_W-1:0]         cnt_ext;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [COEF_W-1:0] rd_data;
  eval_req_t                req;
  eval_res_t                res;
  logic                     res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
      count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER: lower_r <= $signed(cfg_data);
        CFG_UPPER: upper_r <= $signed(cfg_data);
        CFG_COUNT: count_r <= cfg_data[CNT_W-1:0];
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  // one request at a time; loads finish in their accept cycle
  assign in_chan.ready = engine_idle;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign slot_ok       = CMP_W'(in_chan.coef_index) < CMP_W'(MAX_COEFFICIENTS);
  assign load_fire     = in_fire && (in_chan.operation == OP_LOAD) && slot_ok;

  // top coefficient index: count clamped to 1 .. MAX_COEFFICIENTS
  always_comb begin
    cnt_ext = CMP_W'(count_r);
    if (cnt_ext == '0) begin
      k_start = '0;
    end else if (cnt_ext > CMP_W'(MAX_COEFFICIENTS)) begin
      k_start = ADDR_W'(MAX_COEFFICIENTS - 1);
    end else begin
      k_start = ADDR_W'(cnt_ext - CMP_W'(1));
    end
  end

  // exact numerator 2x - a - b and denominator b - a
  logic [COEF_W:0] den_full;
  always_comb begin
    den_full     = {upper_r[COEF_W-1], upper_r} - {lower_r[COEF_W-1], lower_r};
    req.start    = in_fire && (in_chan.operation == OP_EVAL);
    req.inverted = (upper_r <= lower_r);
    req.last     = in_chan.last_point;
    req.num      = $signed({{2{in_chan.x_value[COEF_W-1]}}, in_chan.x_value, 1'b0}
                 - {{3{lower_r[COEF_W-1]}}, lower_r}
                 - {{3{upper_r[COEF_W-1]}}, upper_r});
    req.den      = den_full[COEF_W-1:0];
  end

  cse_coef_ram #(
    .DEPTH(MAX_COEFFICIENTS)
  ) u_ram (
    .clk  (clk),
    .we   (load_fire),
    .waddr(ADDR_W'(in_chan.coef_index)),
    .wdata(in_chan.coef_value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  cse_clenshaw #(
    .MAX_COEFFICIENTS(MAX_COEFFICIENTS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .k_start  (k_start),
    .idle     (engine_idle),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res      (res),
    .res_ready(res_ready)
  );

  // result register: refilled in the cycle it empties
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_y_r      <= res.y;
      out_status_r <= res.status;
      out_bend_r   <= res.batch_end;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.y_value   = out_y_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.batch_end = out_bend_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_chan.ready)
    else $error("request taken while a result is pending in the engine");

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_ready) |=> out_valid_r)
    else $error("result lost on its way to the output register");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.operation == OP_LOAD) |=> engine_idle)
    else $error("load request started the engine");

endmodule

// ===== sv/cse_coef_ram.sv =====
// coefficient store, one write port and one registered read port
module cse_coef_ram import cse_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic signed [COEF_W-1:0] wdata,
  input  logic [ADDR_W-1:0]        raddr,
  output logic signed [COEF_W-1:0] rdata
);

  logic signed [COEF_W-1:0] mem [DEPTH];
  logic signed [COEF_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/cse_map_div.sv =====
// restoring divider for the q2.30 interval coordinate
module cse_map_div import cse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(QUO_W);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [MAG_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         q_r, q_nxt;
  logic [COEF_W-1:0]        den_r, den_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [COEF_W-1:0] t_r, t_nxt;

  logic [NUM_W-1:0]  num_abs;
  logic [MAG_W-1:0]  den_ext;
  logic [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]  kept;
  logic              ge;
  logic [QUO_W-1:0]  q_fin;
  logic [COEF_W-1:0] t_mag;

  always_comb begin
    num_abs = req.num[NUM_W-1] ? (~req.num + NUM_W'(1)) : req.num;
    den_ext = {2'b00, den_r};
    ge      = rem_r >= den_ext;
    diff    = rem_r - den_ext;
    kept    = ge ? diff : rem_r;
    q_fin   = {q_r[QUO_W-2:0], ge};
    t_mag   = {1'b0, q_fin};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    t_nxt    = t_r;

    if (busy_r) begin
      rem_nxt = {kept[MAG_W-2:0], 1'b0};
      q_nxt   = q_fin;
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        t_nxt    = neg_r ? $signed(~t_mag + COEF_W'(1)) : $signed(t_mag);
      end
    end else if (req.start) begin
      neg_nxt = req.num[NUM_W-1];
      den_nxt = req.den;
      // quotient would not fit in q2.30
      if (num_abs[MAG_W-1:0] >= {1'b0, req.den, 1'b0}) begin
        done_nxt = 1'b1;
        t_nxt    = req.num[NUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        busy_nxt = 1'b1;
        rem_nxt  = num_abs[MAG_W-1:0];
        q_nxt    = '0;
        cnt_nxt  = CNT_BITS'(QUO_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    t_r   <= t_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.t    = t_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("divider reports done while still iterating");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < {1'b0, den_r, 1'b0}))
    else $error("partial remainder out of range");

endmodule

// ===== sv/cse_clenshaw.sv =====
// sequencer and multiply-accumulate of the clenshaw recurrence
module cse_clenshaw import cse_pkg::*; #(
  parameter int MAX_COEFFICIENTS = 16,
  localparam int ADDR_W = (MAX_COEFFICIENTS > 1) ? $clog2(MAX_COEFFICIENTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  eval_req_t                req,
  input  logic [ADDR_W-1:0]        k_start,
  output logic                     idle,
  output logic [ADDR_W-1:0]        rd_addr,
  input  logic signed [COEF_W-1:0] rd_data,
  output eval_res_t                res,
  input  logic                     res_ready
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_RES  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        k_r, k_nxt;
  logic signed [COEF_W-1:0] t_r, t_nxt;
  logic signed [COEF_W-1:0] d1_r, d1_nxt;
  logic signed [COEF_W-1:0] d2_r, d2_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [COEF_W-1:0] y_r, y_nxt;
  logic                     status_r, status_nxt;
  logic                     bend_r, bend_nxt;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [PROD_W-1:0] p29, p30;
  logic [NUM_W-1:0]         sh;
  logic [ACC_W-1:0]         sum;
  logic signed [COEF_W-1:0] sum_sat;

  cse_map_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_comb begin
    div_req.start = (state_r == ST_IDLE) && req.start && !req.inverted;
    div_req.num   = req.num;
    div_req.den   = req.den;
  end

  // floor(t * d1 / 2^s) - d2 + c, then clamp to 32 bits
  always_comb begin
    p29 = prod_r >>> 29;
    p30 = prod_r >>> 30;
    sh  = (k_r == '0) ? p30[NUM_W-1:0] : p29[NUM_W-1:0];
    sum = {{(ACC_W-NUM_W){sh[NUM_W-1]}}, sh}
        - {{(ACC_W-COEF_W){d2_r[COEF_W-1]}}, d2_r}
        + {{(ACC_W-COEF_W){rd_data[COEF_W-1]}}, rd_data};
    if (!sum[ACC_W-1] && (|sum[ACC_W-2:COEF_W-1])) begin
      sum_sat = SAT_MAX;
    end else if (sum[ACC_W-1] && !(&sum[ACC_W-2:COEF_W-1])) begin
      sum_sat = SAT_MIN;
    end else begin
      sum_sat = $signed(sum[COEF_W-1:0]);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    t_nxt      = t_r;
    d1_nxt     = d1_r;
    d2_nxt     = d2_r;
    prod_nxt   = prod_r;
    y_nxt      = y_r;
    status_nxt = status_r;
    bend_nxt   = bend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          k_nxt      = k_start;
          bend_nxt   = req.last;
          status_nxt = req.inverted;
          d1_nxt     = '0;
          d2_nxt     = '0;
          if (req.inverted) begin
            y_nxt     = '0;
            state_nxt = ST_RES;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          t_nxt     = div_rsp.t;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = t_r * d1_r;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (k_r == '0) begin
          y_nxt     = sum_sat;
          state_nxt = ST_RES;
        end else begin
          d2_nxt    = d1_r;
          d1_nxt    = sum_sat;
          k_nxt     = k_r - ADDR_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_RES: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    t_r      <= t_nxt;
    d1_r     <= d1_nxt;
    d2_r     <= d2_nxt;
    prod_r   <= prod_nxt;
    y_r      <= y_nxt;
    status_r <= status_nxt;
    bend_r   <= bend_nxt;
  end

  assign idle          = (state_r == ST_IDLE);
  assign rd_addr       = k_r;
  assign res.valid     = (state_r == ST_RES);
  assign res.y         = y_r;
  assign res.status    = status_r;
  assign res.batch_end = bend_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_final_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && $past(state_r) == ST_ACC) |-> ($past(k_r) == '0))
    else $error("result taken before the constant term");

  a_inverted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && status_r) |-> (y_r == '0))
    else $error("inverted interval gives a nonzero value");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_ACC) |->
      ({1'b0, k_r} < (ADDR_W + 1)'(MAX_COEFFICIENTS)))
    else $error("coefficient index beyond the store");

endmodule

// ===== tb/chebyshev_series_evaluator_checker.sv =====
// checker: predicts each series value and compares it with the result channel
`timescale 1ns / 1ps
module chebyshev_series_evaluator_checker import cse_pkg::*; #(
  parameter int MAX_COEFFICIENTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  cse_in_if                    in_chan,
  cse_out_if                   out_chan,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct {
    logic signed [COEF_W-1:0] y;
    logic                     status;
    logic                     batch_end;
  } series_result_t;

  logic signed [COEF_W-1:0] interval_lo;
  logic signed [COEF_W-1:0] interval_hi;
  logic [CNT_W-1:0]         term_count;
  logic signed [COEF_W-1:0] coef_bank [MAX_COEFFICIENTS];
  series_result_t           series_due [$];

  function automatic longint clamp32(input longint v);
    if (v > longint'(SAT_MAX)) return longint'(SAT_MAX);
    if (v < longint'(SAT_MIN)) return longint'(SAT_MIN);
    return v;
  endfunction

  // clenshaw recurrence on the q2.30 mapped coordinate
  function automatic series_result_t clenshaw_value(input longint x, input logic last);
    series_result_t r;
    longint lo, hi, num, den, mag, t, d1, d2, prev;
    int n, k;
    r.batch_end = last;
    r.status = 1'b0;
    lo = longint'(interval_lo);
    hi = longint'(interval_hi);
    if (hi <= lo) begin
      r.y = '0;
      r.status = 1'b1;
      return r;
    end
    n = int'(term_count);
    if (n < 1) n = 1;
    if (n > MAX_COEFFICIENTS) n = MAX_COEFFICIENTS;
    num = 2 * x - lo - hi;
    den = hi - lo;
    mag = (num < 0) ? -num : num;
    if (mag >= 2 * den) begin
      t = (num < 0) ? longint'(SAT_MIN) : longint'(SAT_MAX);
    end else begin
      t = (mag <<< 30) / den;
      if (num < 0) t = -t;
    end
    d1 = 0;
    d2 = 0;
    for (k = n - 1; k >= 1; k--) begin
      prev = d1;
      d1 = clamp32(((t * d1) >>> 29) - d2 + longint'(coef_bank[k]));
      d2 = prev;
    end
    r.y = COEF_W'(clamp32(((t * d1) >>> 30) - d2 + longint'(coef_bank[0])));
    return r;
  endfunction

  always @(posedge clk) begin
    series_result_t want;
    if (!rst_n) begin
      interval_lo = LOWER_RST;
      interval_hi = UPPER_RST;
      term_count  = COUNT_RST;
      series_due.delete();
    end else begin
      // results first: a request taken at this edge cannot complete at it
      if (out_chan.valid && out_chan.ready) begin
        if (series_due.size() == 0) begin
          $error("unexpected result: y_value %0d status %0d batch_end %0d",
                 out_chan.y_value, out_chan.status, out_chan.batch_end);
          fail_count++;
        end else begin
          want = series_due.pop_front();
          if (out_chan.y_value !== want.y) begin
            $error("y_value: expected %0d, got %0d", want.y, out_chan.y_value);
            fail_count++;
          end
          if (out_chan.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_chan.status);
            fail_count++;
          end
          if (out_chan.batch_end !== want.batch_end) begin
            $error("batch_end: expected %0d, got %0d", want.batch_end, out_chan.batch_end);
            fail_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (in_chan.operation == OP_LOAD) begin
          if (in_chan.coef_index < MAX_COEFFICIENTS)
            coef_bank[in_chan.coef_index] = in_chan.coef_value;
        end else begin
          series_due.push_back(clenshaw_value(longint'(in_chan.x_value),
                                              in_chan.last_point));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWER: interval_lo = cfg_data;
          CFG_UPPER: interval_hi = cfg_data;
          CFG_COUNT: term_count  = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = series_due.size();
  end

endmodule

// ===== tb/chebyshev_series_evaluator_tb.sv =====
// testbench top: stimulus, flow control and verdict for the chebyshev series evaluator
`timescale 1ns / 1ps
module chebyshev_series_evaluator_tb;
  import cse_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index

  localparam int IDLE_PCT       = 21;    // chance per cycle that a side idles
  localparam int SETTLE_CYCLES  = 80;    // covers a full evaluation at sixteen terms
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int RANDOM_ITEMS   = 400;
  localparam int PHASE_ITEMS    = 40;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  cse_in_if  in_chan ();
  cse_out_if out_chan ();

  int fail_count;
  int outstanding;

  // idling switches and the hold-off handshake between stimulus and receiver
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int hold_asks = 0;
  int sent = 0;
  int quiet = 0;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  chebyshev_series_evaluator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  chebyshev_series_evaluator_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // offer one request, called and returning at a falling edge; valid stays
  // high on return so back-to-back requests never drop it within a step
  task automatic push_request(input logic op, input logic [IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] coef,
                              input logic signed [COEF_W-1:0] x, input logic last);
    while (in_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.coef_index <= idx;
    in_chan.coef_value <= coef;
    in_chan.x_value    <= x;
    in_chan.last_point <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // drain: nothing offered, every result back, then room for a trailing load
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // one full register setting, plus a write to the unmapped index
  task automatic apply_setting(input logic signed [COEF_W-1:0] lo,
                               input logic signed [COEF_W-1:0] hi,
                               input logic [COEF_W-1:0] cnt_word);
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, hi);
    write_reg(CFG_COUNT, cnt_word);
    write_reg(CFG_SPARE, $urandom);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, a quiet stretch, and a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (out_gaps) begin
        out_chan.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("chebyshev_series_evaluator_tb: errors");
      $finish;
    end
  end

  initial begin
    logic signed [COEF_W-1:0] lo, hi, a, b, x, coef;
    logic [COEF_W-1:0] cnt_word;
    longint span;
    longint unsigned off;
    int phase, r, k;

    // every input known from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOWER;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.operation = OP_EVAL;
    in_chan.coef_index = '0;
    in_chan.coef_value = '0;
    in_chan.x_value = '0;
    in_chan.last_point = 1'b0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset setting is [0, 1.0] with one term, so y is c[0]
    push_request(OP_LOAD, 4'd0, SAT_MAX, $urandom, 1'($urandom));
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, 32'sd0, 1'b0);
    push_request(OP_LOAD, 4'd0, SAT_MIN, $urandom, 1'($urandom));
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, 32'sd65536, 1'b1);

    // fill every slot before any longer series reads it
    push_request(OP_LOAD, 4'd1, SAT_MIN, $urandom, 1'($urandom));
    push_request(OP_LOAD, 4'd2, SAT_MAX, $urandom, 1'($urandom));
    push_request(OP_LOAD, 4'd3, -32'sd1, $urandom, 1'($urandom));
    for (k = 4; k < 16; k++)
      push_request(OP_LOAD, IDX_W'(k), $urandom_range(0, 2**18) - 2**17, $urandom,
                   1'($urandom));
    push_request(OP_LOAD, 4'd0, 32'sd65536, $urandom, 1'($urandom));
    settle();

    // [-1, 1] with all sixteen terms: both ends, center, and far outside
    apply_setting(-32'sd65536, 32'sd65536, 32'd16);
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, -32'sd65536, 1'b0);
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, 32'sd65536, 1'b0);
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, 32'sd0, 1'b0);
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, SAT_MIN, 1'b0);
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, SAT_MAX, 1'b1);
    settle();

    // empty interval: status set, value zero, batch end still copied
    apply_setting(32'sd65536, 32'sd65536, 32'd4);
    push_request(OP_EVAL, IDX_W'($urandom), $urandom, $urandom, 1'b1);
    settle();

    // random phases, each with its own register setting
    sent = 0;
    for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
      case (phase % 8)
        0: begin
          lo = -32'sd65536;
          hi = 32'sd65536;
          cnt_word = 32'd16;
        end
        1: begin
          lo = SAT_MIN;
          hi = SAT_MAX;
          cnt_word = 32'd0;  // zero terms behaves as one
        end
        2: begin
          lo = $urandom;
          hi = lo;
          cnt_word = $urandom_range(1, 16);
        end
        3: begin
          // inverted, or empty when the draws collide
          a = $urandom;
          b = $urandom;
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
          cnt_word = $urandom_range(1, 16);
        end
        4: begin
          // one-lsb interval, almost every coordinate saturates; stray
          // upper bits in the count write
          lo = $signed($urandom) >>> 1;
          hi = lo + 1;
          cnt_word = ($urandom & ~32'h1f) | 32'd31;
        end
        5: begin
          a = $urandom;
          b = $urandom;
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          cnt_word = $urandom_range(0, 31);
        end
        6: begin
          lo = 32'sd0;
          hi = 32'sd65536 * $urandom_range(1, 1000);
          cnt_word = $urandom_range(1, 16);
        end
        default: begin
          lo = SAT_MAX - 1;
          hi = SAT_MAX;
          cnt_word = 32'd16;
        end
      endcase

      // one phase runs with no idling on either side
      in_gaps = (phase != 1);
      out_gaps = (phase != 1);
      apply_setting(lo, hi, cnt_word);

      // receiver holds off while requests keep coming, filling the block
      if (phase % 8 == 0) hold_asks++;

      span = longint'(hi) - longint'(lo);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          // reload: mostly modest values so series do not pin at the rails
          r = $urandom_range(0, 99);
          if (r < 60)
            coef = $urandom_range(0, 2**19) - 2**18;
          else if (r < 90)
            coef = $urandom_range(0, 2**25) - 2**24;
          else
            coef = $urandom;
          push_request(OP_LOAD, IDX_W'($urandom_range(0, 15)), coef, $urandom,
                       1'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70 && span > 0) begin
            off = {$urandom, $urandom};
            off = off % longint'(span + 1);
            x = COEF_W'(longint'(lo) + longint'(off));
          end else if (r < 85) begin
            x = $urandom;
          end else begin
            case ($urandom_range(0, 4))
              0: x = lo;
              1: x = hi;
              2: x = SAT_MIN;
              3: x = SAT_MAX;
              default: x = '0;
            endcase
          end
          push_request(OP_EVAL, IDX_W'($urandom), $urandom, x, 1'($urandom_range(0, 1)));
        end
      end
      settle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("chebyshev_series_evaluator_tb: clean");
    end else begin
      $display("chebyshev_series_evaluator_tb: errors");
    end
    $finish;
  end

endmodule
